>>> sv/xmr_pkg.sv
// xmr_pkg: shared constants, result type and crc helper for the xmodem receiver
// no dependencies; used by xmodem_receiver_core.sv and the testbench
package xmr_pkg;

	// protocol bytes
	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int SHORT_PACKET_SIZE = 128;

	// input opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// packet marks
	localparam logic [1:0] MARK_NONE    = 2'd0;
	localparam logic [1:0] MARK_COMMIT  = 2'd1;
	localparam logic [1:0] MARK_DISCARD = 2'd2;

	// end status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_START_BAD = 3'd1;
	localparam logic [2:0] ST_ERRORS    = 3'd2;
	localparam logic [2:0] ST_CANCEL    = 3'd3;
	localparam logic [2:0] ST_SIZE      = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_TIMEOUT     = 3'd0;
	localparam logic [2:0] CFG_MAX_ERRORS  = 3'd1;
	localparam logic [2:0] CFG_START_TRIES = 3'd2;
	localparam logic [2:0] CFG_MAX_BYTES   = 3'd3;
	localparam logic [2:0] CFG_CRC_FIRST   = 3'd4;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [1:0]  packet_mark;
		logic        flush_request;
		logic        done_res;
		logic [2:0]  status;
		logic [31:0] total_bytes;
	} result_t;

	// crc-16 (0x1021) update by one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> sv/xmr_if.sv
// xmr_if: valid/ready channels for the xmodem receiver input and result items
// no dependencies; follows xmr_pkg.sv in compile order
interface xmr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;

	modport source (output valid, opcode, rx_byte, input ready);
	modport sink (input valid, opcode, rx_byte, output ready);
endinterface

interface xmr_out_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [1:0]  packet_mark;
	logic        flush_request;
	logic        done_res;
	logic [2:0]  status;
	logic [31:0] total_bytes;

	modport source (output valid, tx_valid, tx_byte, data_valid, data_byte, packet_mark,
		flush_request, done_res, status, total_bytes, input ready);
	modport sink (input valid, tx_valid, tx_byte, data_valid, data_byte, packet_mark,
		flush_request, done_res, status, total_bytes, output ready);
endinterface

>>> sv/xmodem_receiver_core.sv
// xmodem_receiver_core: xmodem / 1k-xmodem receive protocol engine, top level
// depends on xmr_pkg.sv and xmr_if.sv

// The receiver takes one item per clock when not stalled: a start command, a received
// serial byte or a millisecond tick, and returns exactly one result item for each.
// Every item goes through the frame parser, crc/sum update and retry logic
// combinationally and lands in the result register, so the sustained rate is one item
// per cycle while dout.ready holds; the result register is the only stage, and a new
// item is taken whenever that register is empty or being drained in the same cycle. A
// result appears in the cycle after its item is accepted. Reply bytes (C, NAK, ACK)
// come out on tx_valid/tx_byte, payload bytes stream out on data_valid/data_byte as
// they arrive, and a commit or discard mark closes each packet once its number and
// check are known. done_res with status flags the end of a transfer. Configuration
// registers are taken through the plain write port and must only be written while no
// item is in flight; crc_first takes effect at the next start command.
module xmodem_receiver_core #(
	parameter int LONG_PACKET_SIZE = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	xmr_in_if.sink          din,
	xmr_out_if.source       dout
);

	localparam int CNT_W = $clog2(LONG_PACKET_SIZE + 1);

	// receive phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_NUMBER = 3'd2;
	localparam logic [2:0] PH_COMPL  = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CHK_HI = 3'd5;
	localparam logic [2:0] PH_CHK_LO = 3'd6;

	// configuration
	logic [15:0] timeout_ticks_q;
	logic [7:0]  max_errors_q;
	logic [7:0]  start_tries_q;
	logic [31:0] max_bytes_q;
	logic        crc_first_q;

	// protocol state
	logic [2:0]       phase_q, phase_n;
	logic [7:0]       expected_number_q, expected_number_n;
	logic [7:0]       got_number_q, got_number_n;
	logic [7:0]       got_complement_q, got_complement_n;
	logic [CNT_W-1:0] payload_count_q, payload_count_n;
	logic             long_packet_q, long_packet_n;
	logic [15:0]      running_crc_q, running_crc_n;
	logic [7:0]       running_sum_q, running_sum_n;
	logic [15:0]      received_check_q, received_check_n;
	logic             crc_mode_q, crc_mode_n;
	logic             starting_q, starting_n;
	logic [7:0]       fail_count_q, fail_count_n;
	logic [15:0]      idle_ticks_q, idle_ticks_n;
	logic [31:0]      byte_total_q, byte_total_n;

	// result register
	logic                 out_valid_q;
	xmr_pkg::result_t     res_q;
	xmr_pkg::result_t     res;

	logic             accept;
	logic             do_fail;
	logic             do_finish;
	logic             streamed;
	logic [CNT_W-1:0] pkt_size;
	logic [CNT_W-1:0] count_inc;
	logic [7:0]       fail_inc;
	logic [32:0]      total_sum;
	logic             num_ok;
	logic             chk_ok;

	// skid-free single stage: take a new item whenever the result slot frees up
	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;

	assign streamed = (phase_q == PH_DATA && payload_count_q != '0) ||
		phase_q == PH_CHK_HI || phase_q == PH_CHK_LO;
	assign pkt_size  = long_packet_q ? CNT_W'(LONG_PACKET_SIZE)
		: CNT_W'(xmr_pkg::SHORT_PACKET_SIZE);
	assign count_inc = payload_count_q + 1'b1;
	assign fail_inc  = (fail_count_q != 8'hFF) ? fail_count_q + 8'd1 : fail_count_q;
	assign total_sum = {1'b0, byte_total_q} + 33'(pkt_size);

	always_comb begin
		phase_n          = phase_q;
		expected_number_n = expected_number_q;
		got_number_n     = got_number_q;
		got_complement_n = got_complement_q;
		payload_count_n  = payload_count_q;
		long_packet_n    = long_packet_q;
		running_crc_n    = running_crc_q;
		running_sum_n    = running_sum_q;
		received_check_n = received_check_q;
		crc_mode_n       = crc_mode_q;
		starting_n       = starting_q;
		fail_count_n     = fail_count_q;
		idle_ticks_n     = idle_ticks_q;
		byte_total_n     = byte_total_q;
		res              = '0;
		do_fail          = 1'b0;
		do_finish        = 1'b0;
		num_ok           = 1'b0;
		chk_ok           = 1'b0;

		unique case (din.opcode)
			xmr_pkg::OP_START: begin
				// start or restart; anything already streamed gets thrown away
				if (streamed) begin
					res.packet_mark = xmr_pkg::MARK_DISCARD;
				end
				expected_number_n = 8'd1;
				fail_count_n      = '0;
				crc_mode_n        = crc_first_q;
				starting_n        = 1'b1;
				byte_total_n      = '0;
				idle_ticks_n      = '0;
				payload_count_n   = '0;
				phase_n           = PH_HEADER;
				res.flush_request = 1'b1;
				res.tx_valid      = 1'b1;
				res.tx_byte       = crc_first_q ? xmr_pkg::B_C : xmr_pkg::B_NAK;
			end
			xmr_pkg::OP_BYTE: begin
				if (phase_q != PH_IDLE) begin
					idle_ticks_n = '0;
					unique case (phase_q)
						PH_HEADER: begin
							if (din.rx_byte == xmr_pkg::B_SOH || din.rx_byte == xmr_pkg::B_STX) begin
								long_packet_n = (din.rx_byte == xmr_pkg::B_STX);
								phase_n       = PH_NUMBER;
							end else if (din.rx_byte == xmr_pkg::B_EOT) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = xmr_pkg::B_ACK;
								fail_count_n = '0;
								res.done_res = 1'b1;
								res.status   = xmr_pkg::ST_OK;
								phase_n      = PH_IDLE;
							end else if (din.rx_byte == xmr_pkg::B_CAN) begin
								res.flush_request = 1'b1;
								res.done_res      = 1'b1;
								res.status        = xmr_pkg::ST_CANCEL;
								phase_n           = PH_IDLE;
							end else begin
								do_fail = 1'b1;
							end
						end
						PH_NUMBER: begin
							got_number_n = din.rx_byte;
							phase_n      = PH_COMPL;
						end
						PH_COMPL: begin
							got_complement_n = din.rx_byte;
							payload_count_n  = '0;
							running_crc_n    = '0;
							running_sum_n    = '0;
							phase_n          = PH_DATA;
						end
						PH_DATA: begin
							res.data_valid  = 1'b1;
							res.data_byte   = din.rx_byte;
							running_sum_n   = running_sum_q + din.rx_byte;
							running_crc_n   = xmr_pkg::crc_byte(running_crc_q, din.rx_byte);
							payload_count_n = count_inc;
							if (count_inc >= pkt_size) begin
								phase_n = PH_CHK_HI;
							end
						end
						PH_CHK_HI: begin
							if (crc_mode_q) begin
								received_check_n = {din.rx_byte, 8'h00};
								phase_n          = PH_CHK_LO;
							end else begin
								received_check_n = {8'h00, din.rx_byte};
								do_finish        = 1'b1;
							end
						end
						PH_CHK_LO: begin
							received_check_n = {received_check_q[15:8], din.rx_byte};
							do_finish        = 1'b1;
						end
						default: ;
					endcase
				end
			end
			xmr_pkg::OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					idle_ticks_n = (idle_ticks_q != 16'hFFFF) ? idle_ticks_q + 16'd1
						: idle_ticks_q;
					if (idle_ticks_n >= timeout_ticks_q) begin
						if (streamed) begin
							res.packet_mark = xmr_pkg::MARK_DISCARD;
						end
						do_fail = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// end of packet: number/complement and check decide commit or discard
		if (do_finish) begin
			num_ok = (got_number_q == ~got_complement_q) &&
				(got_number_q == expected_number_q);
			chk_ok = crc_mode_q ? (running_crc_q == received_check_n)
				: (running_sum_q == received_check_n[7:0]);
			if (!(num_ok && chk_ok)) begin
				res.packet_mark = xmr_pkg::MARK_DISCARD;
				do_fail         = 1'b1;
			end else begin
				res.packet_mark   = xmr_pkg::MARK_COMMIT;
				expected_number_n = expected_number_q + 8'd1;
				fail_count_n      = '0;
				starting_n        = 1'b0;
				byte_total_n      = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
				phase_n           = PH_HEADER;
				if (byte_total_n >= max_bytes_q) begin
					res.done_res = 1'b1;
					res.status   = xmr_pkg::ST_SIZE;
					phase_n      = PH_IDLE;
				end else begin
					res.tx_valid = 1'b1;
					res.tx_byte  = xmr_pkg::B_ACK;
				end
			end
		end

		// timeout or bad packet: retry, fall back to checksum, or give up
		if (do_fail) begin
			res.flush_request = 1'b1;
			idle_ticks_n      = '0;
			phase_n           = PH_HEADER;
			fail_count_n      = fail_inc;
			if (starting_q) begin
				if (fail_inc >= start_tries_q && !crc_mode_q) begin
					res.done_res = 1'b1;
					res.status   = xmr_pkg::ST_START_BAD;
					phase_n      = PH_IDLE;
				end else if (fail_inc >= start_tries_q) begin
					crc_mode_n   = 1'b0;
					fail_count_n = '0;
					res.tx_valid = 1'b1;
					res.tx_byte  = xmr_pkg::B_NAK;
				end else begin
					res.tx_valid = 1'b1;
					res.tx_byte  = crc_mode_q ? xmr_pkg::B_C : xmr_pkg::B_NAK;
				end
			end else begin
				res.tx_valid = 1'b1;
				res.tx_byte  = xmr_pkg::B_NAK;
				if (fail_inc >= max_errors_q) begin
					res.done_res = 1'b1;
					res.status   = xmr_pkg::ST_ERRORS;
					phase_n      = PH_IDLE;
				end
			end
		end

		res.total_bytes = byte_total_n;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= 16'd3000;
			max_errors_q    <= 8'd10;
			start_tries_q   <= 8'd5;
			max_bytes_q     <= 32'hFFFF_FFFF;
			crc_first_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xmr_pkg::CFG_TIMEOUT:     timeout_ticks_q <= cfg_data[15:0];
				xmr_pkg::CFG_MAX_ERRORS:  max_errors_q    <= cfg_data[7:0];
				xmr_pkg::CFG_START_TRIES: start_tries_q   <= cfg_data[7:0];
				xmr_pkg::CFG_MAX_BYTES:   max_bytes_q     <= cfg_data;
				xmr_pkg::CFG_CRC_FIRST:   crc_first_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// protocol state advances on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_IDLE;
			expected_number_q <= 8'd1;
			got_number_q      <= '0;
			got_complement_q  <= '0;
			payload_count_q   <= '0;
			long_packet_q     <= 1'b0;
			running_crc_q     <= '0;
			running_sum_q     <= '0;
			received_check_q  <= '0;
			crc_mode_q        <= 1'b1;
			starting_q        <= 1'b1;
			fail_count_q      <= '0;
			idle_ticks_q      <= '0;
			byte_total_q      <= '0;
		end else if (accept) begin
			phase_q           <= phase_n;
			expected_number_q <= expected_number_n;
			got_number_q      <= got_number_n;
			got_complement_q  <= got_complement_n;
			payload_count_q   <= payload_count_n;
			long_packet_q     <= long_packet_n;
			running_crc_q     <= running_crc_n;
			running_sum_q     <= running_sum_n;
			received_check_q  <= received_check_n;
			crc_mode_q        <= crc_mode_n;
			starting_q        <= starting_n;
			fail_count_q      <= fail_count_n;
			idle_ticks_q      <= idle_ticks_n;
			byte_total_q      <= byte_total_n;
		end
	end

	// result slot: full after an accept, empty once taken with nothing new behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.tx_valid      = res_q.tx_valid;
	assign dout.tx_byte       = res_q.tx_byte;
	assign dout.data_valid    = res_q.data_valid;
	assign dout.data_byte     = res_q.data_byte;
	assign dout.packet_mark   = res_q.packet_mark;
	assign dout.flush_request = res_q.flush_request;
	assign dout.done_res      = res_q.done_res;
	assign dout.status        = res_q.status;
	assign dout.total_bytes   = res_q.total_bytes;

endmodule
